>>> hdl/tfs_pkg.sv
package tfs_pkg;

    localparam int FLOW_ENTRIES = 64;
    localparam int IDX_W        = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;

    localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6  = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [15:0] ETH_HDR_LEN = 16'd14;
    localparam logic [15:0] IPV4_END    = 16'd34;
    localparam logic [15:0] IPV6_END    = 16'd54;
    localparam logic [15:0] TCP_END     = 16'd54;

    localparam logic [15:0] SVC_PORT_DEFAULT  = 16'd443;
    localparam logic [15:0] MIN_COUNT_DEFAULT = 16'd3;

    localparam logic CFG_SERVICE_PORT = 1'b0;
    localparam logic CFG_MIN_COUNT    = 1'b1;

    localparam logic [2:0] ACT_UNTRACKED = 3'd0;
    localparam logic [2:0] ACT_CREATED   = 3'd1;
    localparam logic [2:0] ACT_CLOSED    = 3'd2;
    localparam logic [2:0] ACT_COUNTED   = 3'd3;
    localparam logic [2:0] ACT_FULL      = 3'd4;
    localparam logic [2:0] ACT_UNKNOWN   = 3'd5;

    localparam int FLG_SYN = 0;
    localparam int FLG_ACK = 1;
    localparam int FLG_RST = 2;
    localparam int FLG_FIN = 3;

    typedef struct packed {
        logic [15:0] frame_length;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [3:0]  tcp_flags;
        logic [63:0] arrival_time;
    } t_item;

    typedef struct packed {
        logic        verdict;
        logic [2:0]  action;
        logic [31:0] flow_packets;
        logic [63:0] flow_bytes;
        logic [63:0] flow_squares;
        logic [63:0] flow_start;
        logic [63:0] flow_last;
        logic [63:0] flow_end;
    } t_result;

    typedef struct packed {
        logic        valid;
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] packets;
        logic [63:0] bytes;
        logic [63:0] squares;
        logic [63:0] start_time;
        logic [63:0] last_time;
        logic [63:0] end_time;
    } t_entry;

endpackage

>>> hdl/tfs_cell.sv
module tfs_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tfs_pkg::t_entry i_prev,
    input  logic            i_load,
    input  tfs_pkg::t_entry i_load_entry,
    output tfs_pkg::t_entry o_entry
);
    import tfs_pkg::*;

    t_entry n_entry;
    logic   r_valid;
    t_entry r_data;

    // take the neighbor's entry, or the rewritten one
    assign n_entry = i_load ? i_load_entry : i_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_entry;
    end

    always_comb begin
        o_entry       = r_data;
        o_entry.valid = r_valid;
    end

endmodule

>>> hdl/tcp_flow_stats_tracker.sv
// TCP flow statistics tracker.
//
// Input: one frame header summary word on i_in, taken at a rising edge with
// i_start high and o_busy low. Config: i_cfg_we writes i_cfg_data into
// register i_cfg_addr (0 service port, 1 minimum packet count); write only
// while o_busy is low.
// Output: one result word on o_result per input word, flagged by o_valid for
// exactly one cycle. The receiver cannot stall; it must take it then.
//
// The flow table is a ring of FLOW_ENTRIES cells that rotates by one cell
// every cycle; the entry leaving the last cell is the only one examined or
// rewritten. Untracked frames answer in the cycle after acceptance and never
// raise o_busy. A tracked frame is checked against every entry for its key
// and the lowest free entry as the ring goes round (ST_SCAN), is decided in
// ST_DECIDE, and then waits in ST_APPLY until the target entry comes round;
// with no target (table full or unknown flow) it answers from ST_DECIDE.
//
// Reset clears all valid bits at once (no clearing pass) and loads the
// registers with port 443 and minimum count 3.
module tcp_flow_stats_tracker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  tfs_pkg::t_item   i_in,
    output logic             o_valid,
    output tfs_pkg::t_result o_result,
    input  logic             i_cfg_we,
    input  logic             i_cfg_addr,
    input  logic [15:0]      i_cfg_data
);
    import tfs_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_APPLY  = 2'd3;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOW_ENTRIES - 1);

    logic [1:0]       r_state, n_state;
    logic [15:0]      r_service_port, r_min_count;
    logic [IDX_W-1:0] r_ptr;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    t_item            r_item, n_item;
    logic [15:0]      r_pay, n_pay;
    logic [31:0]      r_sq, n_sq;
    logic             r_hit, n_hit;
    logic [IDX_W-1:0] r_hit_idx, n_hit_idx;
    logic             r_free, n_free;
    logic [IDX_W-1:0] r_free_idx, n_free_idx;
    logic [IDX_W-1:0] r_tgt, n_tgt;
    logic             r_valid, n_valid;
    t_result          r_result, n_result;

    t_entry w_cells [FLOW_ENTRIES];
    t_entry w_head;
    t_entry w_new;
    logic   w_load;
    logic   w_accept;
    logic   w_tracked;
    logic   w_drop;
    logic   w_open;
    logic   w_close;
    logic   w_key_eq;
    logic [31:0] w_pk;

    // ring of cells: cell 0 is fed by the last cell or by the rewrite
    for (genvar g = 0; g < FLOW_ENTRIES; g++) begin : g_cell
        tfs_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_prev       (w_cells[(g + FLOW_ENTRIES - 1) % FLOW_ENTRIES]),
            .i_load       ((g == 0) ? w_load : 1'b0),
            .i_load_entry (w_new),
            .o_entry      (w_cells[g])
        );
    end

    assign w_head   = w_cells[FLOW_ENTRIES-1];
    assign w_accept = i_start && !o_busy;
    assign o_busy   = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    assign w_open  = r_item.tcp_flags[FLG_SYN] && r_item.tcp_flags[FLG_ACK];
    assign w_close = r_item.tcp_flags[FLG_RST] || r_item.tcp_flags[FLG_FIN];
    assign w_key_eq = w_head.valid && (w_head.saddr == r_item.source_address)
                      && (w_head.daddr == r_item.dest_address)
                      && (w_head.sport == r_item.source_port)
                      && (w_head.dport == r_item.dest_port);
    assign w_pk = w_head.packets + 32'd1;

    // classify the incoming header
    always_comb begin
        w_tracked = 1'b0;
        w_drop    = 1'b0;
        if (i_in.frame_length < ETH_HDR_LEN) begin
            w_drop = 1'b1;
        end else if (i_in.ether_type == ETYPE_IPV6) begin
            w_drop = (i_in.frame_length < IPV6_END);
        end else if (i_in.ether_type != ETYPE_IPV4) begin
            w_drop = 1'b0;
        end else if (i_in.frame_length < IPV4_END) begin
            w_drop = 1'b1;
        end else if (i_in.ip_protocol != PROTO_TCP) begin
            w_drop = 1'b0;
        end else if (i_in.frame_length < TCP_END) begin
            w_drop = 1'b1;
        end else begin
            w_tracked = (i_in.source_port == r_service_port) ||
                        (i_in.dest_port == r_service_port);
        end
    end

    // rewritten entry for the target slot
    always_comb begin
        w_new = w_head;
        if (w_open) begin
            w_new.valid      = 1'b1;
            w_new.saddr      = r_item.source_address;
            w_new.daddr      = r_item.dest_address;
            w_new.sport      = r_item.source_port;
            w_new.dport      = r_item.dest_port;
            w_new.packets    = '0;
            w_new.bytes      = '0;
            w_new.squares    = '0;
            w_new.start_time = r_item.arrival_time;
            w_new.last_time  = r_item.arrival_time;
            w_new.end_time   = '0;
        end else if (w_close) begin
            w_new.last_time = r_item.arrival_time;
            w_new.end_time  = r_item.arrival_time;
        end else begin
            w_new.packets   = w_pk;
            w_new.last_time = r_item.arrival_time;
            if (w_pk >= {16'd0, r_min_count}) begin
                w_new.bytes   = w_head.bytes + {48'd0, r_pay};
                w_new.squares = w_head.squares + {32'd0, r_sq};
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_item     = r_item;
        n_pay      = r_pay;
        n_sq       = r_sq;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_tgt      = r_tgt;
        n_valid    = 1'b0;
        n_result   = r_result;
        w_load     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_tracked) begin
                        // latch the header and start a full lap
                        n_item  = i_in;
                        n_pay   = i_in.frame_length - TCP_END;
                        n_state = ST_SCAN;
                        n_cnt   = '0;
                        n_hit   = 1'b0;
                        n_free  = 1'b0;
                    end else begin
                        n_valid  = 1'b1;
                        n_result = '0;
                        n_result.verdict = w_drop;
                        n_result.action  = ACT_UNTRACKED;
                    end
                end
            end
            ST_SCAN: begin
                n_sq = r_pay * r_pay;
                if (w_key_eq) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_ptr;
                end
                if (!w_head.valid && (!r_free || (r_ptr < r_free_idx))) begin
                    n_free     = 1'b1;
                    n_free_idx = r_ptr;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_result = '0;
                if (r_hit) begin
                    n_tgt   = r_hit_idx;
                    n_state = ST_APPLY;
                end else if (w_open && r_free) begin
                    n_tgt   = r_free_idx;
                    n_state = ST_APPLY;
                end else begin
                    // no target: table full or unknown flow
                    n_valid         = 1'b1;
                    n_result.action = w_open ? ACT_FULL : ACT_UNKNOWN;
                    n_state         = ST_IDLE;
                end
            end
            ST_APPLY: begin
                if (r_ptr == r_tgt) begin
                    w_load  = 1'b1;
                    n_valid = 1'b1;
                    n_result.verdict      = 1'b0;
                    n_result.action       = w_open ? ACT_CREATED :
                                            (w_close ? ACT_CLOSED : ACT_COUNTED);
                    n_result.flow_packets = w_new.packets;
                    n_result.flow_bytes   = w_new.bytes;
                    n_result.flow_squares = w_new.squares;
                    n_result.flow_start   = w_new.start_time;
                    n_result.flow_last    = w_new.last_time;
                    n_result.flow_end     = w_new.end_time;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_valid        <= 1'b0;
            r_ptr          <= LAST_IDX;
            r_service_port <= SVC_PORT_DEFAULT;
            r_min_count    <= MIN_COUNT_DEFAULT;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            // advance the index of the entry at the ring head
            r_ptr   <= (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_SERVICE_PORT: r_service_port <= i_cfg_data;
                    CFG_MIN_COUNT:    r_min_count    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_item     <= n_item;
        r_pay      <= n_pay;
        r_sq       <= n_sq;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_tgt      <= n_tgt;
        r_result   <= n_result;
    end

endmodule

>>> bench/tcp_flow_stats_tracker_tb.sv
`timescale 1ns / 100ps

module tcp_flow_stats_tracker_tb;
    import tfs_pkg::*;

    // Predicted flow table and the queue of results still owed by the block.
    class flow_scoreboard;
        t_entry      table_q[FLOW_ENTRIES];
        logic [15:0] svc_port;
        logic [15:0] min_pkts;
        t_result     owed_q[$];
        int          errors;

        function void clear();
            for (int i = 0; i < FLOW_ENTRIES; i++) table_q[i] = '0;
            svc_port = SVC_PORT_DEFAULT;
            min_pkts = MIN_COUNT_DEFAULT;
            owed_q.delete();
            errors = 0;
        endfunction

        function void set_reg(logic addr, logic [15:0] data);
            if (addr == CFG_SERVICE_PORT) svc_port = data;
            else min_pkts = data;
        endfunction

        function automatic t_result make_res(logic v, logic [2:0] a, int e);
            t_result r;
            r = '0;
            r.verdict = v;
            r.action = a;
            if (e >= 0) begin
                r.flow_packets = table_q[e].packets;
                r.flow_bytes   = table_q[e].bytes;
                r.flow_squares = table_q[e].squares;
                r.flow_start   = table_q[e].start_time;
                r.flow_last    = table_q[e].last_time;
                r.flow_end     = table_q[e].end_time;
            end
            return r;
        endfunction

        // Apply one accepted frame to the table and queue the expected word.
        function void note_frame(t_item it);
            int          hit;
            int          slot;
            logic [63:0] pay;
            hit = -1;
            slot = -1;
            if (it.frame_length < ETH_HDR_LEN) begin
                owed_q.push_back(make_res(1'b1, ACT_UNTRACKED, -1)); return;
            end
            if (it.ether_type == ETYPE_IPV6) begin
                owed_q.push_back(make_res(it.frame_length < IPV6_END, ACT_UNTRACKED, -1));
                return;
            end
            if (it.ether_type != ETYPE_IPV4) begin
                owed_q.push_back(make_res(1'b0, ACT_UNTRACKED, -1)); return;
            end
            if (it.frame_length < IPV4_END) begin
                owed_q.push_back(make_res(1'b1, ACT_UNTRACKED, -1)); return;
            end
            if (it.ip_protocol != PROTO_TCP) begin
                owed_q.push_back(make_res(1'b0, ACT_UNTRACKED, -1)); return;
            end
            if (it.frame_length < TCP_END) begin
                owed_q.push_back(make_res(1'b1, ACT_UNTRACKED, -1)); return;
            end
            if (it.source_port != svc_port && it.dest_port != svc_port) begin
                owed_q.push_back(make_res(1'b0, ACT_UNTRACKED, -1)); return;
            end
            for (int i = FLOW_ENTRIES - 1; i >= 0; i--) begin
                if (table_q[i].valid && table_q[i].saddr == it.source_address &&
                    table_q[i].daddr == it.dest_address &&
                    table_q[i].sport == it.source_port &&
                    table_q[i].dport == it.dest_port) hit = i;
                if (!table_q[i].valid) slot = i;
            end
            if (it.tcp_flags[FLG_SYN] && it.tcp_flags[FLG_ACK]) begin
                if (hit < 0) hit = slot;
                if (hit < 0) begin
                    owed_q.push_back(make_res(1'b0, ACT_FULL, -1)); return;
                end
                table_q[hit] = '0;
                table_q[hit].valid = 1'b1;
                table_q[hit].saddr = it.source_address;
                table_q[hit].daddr = it.dest_address;
                table_q[hit].sport = it.source_port;
                table_q[hit].dport = it.dest_port;
                table_q[hit].start_time = it.arrival_time;
                table_q[hit].last_time = it.arrival_time;
                owed_q.push_back(make_res(1'b0, ACT_CREATED, hit));
                return;
            end
            if (hit < 0) begin
                owed_q.push_back(make_res(1'b0, ACT_UNKNOWN, -1)); return;
            end
            if (it.tcp_flags[FLG_RST] || it.tcp_flags[FLG_FIN]) begin
                table_q[hit].last_time = it.arrival_time;
                table_q[hit].end_time = it.arrival_time;
                owed_q.push_back(make_res(1'b0, ACT_CLOSED, hit));
                return;
            end
            table_q[hit].packets = table_q[hit].packets + 1;
            if (table_q[hit].packets >= {16'd0, min_pkts}) begin
                pay = it.frame_length - TCP_END;
                table_q[hit].bytes = table_q[hit].bytes + pay;
                table_q[hit].squares = table_q[hit].squares + pay * pay;
            end
            table_q[hit].last_time = it.arrival_time;
            owed_q.push_back(make_res(1'b0, ACT_COUNTED, hit));
        endfunction

        function void check_word(t_result got);
            t_result want;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.verdict !== want.verdict)
                $display("%0t: verdict exp %h got %h", $time, want.verdict, got.verdict);
            if (got.action !== want.action)
                $display("%0t: action exp %h got %h", $time, want.action, got.action);
            if (got.flow_packets !== want.flow_packets)
                $display("%0t: packets exp %h got %h", $time,
                         want.flow_packets, got.flow_packets);
            if (got.flow_bytes !== want.flow_bytes)
                $display("%0t: bytes exp %h got %h", $time, want.flow_bytes, got.flow_bytes);
            if (got.flow_squares !== want.flow_squares)
                $display("%0t: squares exp %h got %h", $time,
                         want.flow_squares, got.flow_squares);
            if (got.flow_start !== want.flow_start)
                $display("%0t: start exp %h got %h", $time, want.flow_start, got.flow_start);
            if (got.flow_last !== want.flow_last)
                $display("%0t: last exp %h got %h", $time, want.flow_last, got.flow_last);
            if (got.flow_end !== want.flow_end)
                $display("%0t: end exp %h got %h", $time, want.flow_end, got.flow_end);
            if (got !== want) errors++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    t_item       in_word;
    logic        res_valid;
    t_result     res_word;
    logic        cfg_we;
    logic        cfg_addr;
    logic [15:0] cfg_data;

    flow_scoreboard sb;
    int             send_gap_pct;
    logic [31:0]    addr_pool[4];
    logic [15:0]    port_pool[3];

    tcp_flow_stats_tracker u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_in       (in_word),
        .o_valid    (res_valid),
        .o_result   (res_word),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Check results on the edge that ends their strobe cycle.
    always @(posedge clk) begin
        if (rst_n && res_valid) sb.check_word(res_word);
    end

    // Offer one word, hold it until accepted, then note it. Start stays high
    // after acceptance; the next send, an idle cycle or a drain drops or
    // reloads it at that same edge.
    task automatic send_word(t_item it);
        while ($urandom_range(99) < send_gap_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        in_word <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_frame(it);
    endtask

    // Hold start low and wait until every owed word is in before a register write.
    task automatic drain();
        start <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge clk);
        repeat (2 * FLOW_ENTRIES + 4) @(posedge clk);
    endtask

    task automatic write_reg(logic addr, logic [15:0] data);
        drain();
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(addr, data);
    endtask

    // Build a tracked TCP frame on a small key pool so flows recur.
    function automatic t_item tracked_frame(logic [3:0] flags);
        t_item it;
        it.frame_length   = ($urandom_range(9) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(1554, 54));
        it.ether_type     = ETYPE_IPV4;
        it.ip_protocol    = PROTO_TCP;
        it.source_address = addr_pool[2'($urandom_range(3))];
        it.dest_address   = addr_pool[2'($urandom_range(3))];
        if ($urandom_range(1)) begin
            it.source_port = sb.svc_port;
            it.dest_port   = port_pool[2'($urandom_range(2))];
        end else begin
            it.source_port = port_pool[2'($urandom_range(2))];
            it.dest_port   = sb.svc_port;
        end
        it.tcp_flags      = flags;
        it.arrival_time   = {$urandom, $urandom};
        return it;
    endfunction

    function automatic t_item noise_frame();
        t_item        it;
        logic [223:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(t_item)-1:0];
        case ($urandom_range(3))
            0: it.ether_type = ETYPE_IPV6;
            1: it.ether_type = ETYPE_IPV4;
            2: begin
                it.ether_type = ETYPE_IPV4;
                it.ip_protocol = PROTO_TCP;
            end
            default: ;
        endcase
        if ($urandom_range(1)) it.frame_length = 16'($urandom_range(70));
        return it;
    endfunction

    function automatic t_item random_frame();
        logic [3:0] flags;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 20) return noise_frame();
        flags = 4'($urandom);
        if (pick < 45) flags = 4'b0011 | flags;
        else if (pick < 85) flags = flags & 4'b0011 & ~4'b0001 | 4'($urandom_range(1)) & 4'b0001;
        return tracked_frame(flags);
    endfunction

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) send_word(random_frame());
    endtask

    initial begin
        t_item it;
        sb = new();
        sb.clear();
        rst_n = 1'b0;
        start = 1'b0;
        in_word = '0;
        cfg_we = 1'b0;
        cfg_addr = CFG_SERVICE_PORT;
        cfg_data = '0;
        send_gap_pct = 0;
        for (int i = 0; i < 4; i++) addr_pool[i] = $urandom;
        port_pool[0] = 16'h0000;
        port_pool[1] = 16'hFFFF;
        port_pool[2] = 16'($urandom);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: header length and type cases at their edges.
        it = '0;                              send_word(it);
        it.frame_length = 16'd13;             send_word(it);
        it.frame_length = 16'd14;             send_word(it);
        it.ether_type = ETYPE_IPV6;           send_word(it);
        it.frame_length = 16'd54;             send_word(it);
        it.ether_type = ETYPE_IPV4; it.frame_length = 16'd33; send_word(it);
        it.frame_length = 16'd34; it.ip_protocol = 8'hFF;   send_word(it);
        it.ip_protocol = PROTO_TCP; it.frame_length = 16'd53; send_word(it);
        it.frame_length = 16'hFFFF;           send_word(it);

        // Directed: open, count past threshold, reopen, close, unknown.
        it = tracked_frame(4'b0011);
        it.frame_length = 16'hFFFF;
        it.arrival_time = '1;
        send_word(it);
        it.tcp_flags = 4'b0000; repeat (4) send_word(it);
        it.tcp_flags = 4'b0010; it.frame_length = 16'd54; send_word(it);
        it.tcp_flags = 4'b1111; send_word(it);
        it.tcp_flags = 4'b0100; send_word(it);
        it.tcp_flags = 4'b1000; it.arrival_time = '0; send_word(it);
        it.tcp_flags = 4'b0001; send_word(it);
        it.source_address = ~it.source_address; send_word(it);
        it.tcp_flags = 4'b1000; send_word(it);

        // Fill the table, then hit table full.
        for (int i = 0; i <= FLOW_ENTRIES; i++) begin
            it = tracked_frame(4'b0011);
            it.source_address = 32'hC0000000 + i;
            send_word(it);
        end

        // Pause until everything owed is in, then change settings.
        write_reg(CFG_MIN_COUNT, 16'd0);
        send_gap_pct = 23;
        random_phase(500);
        write_reg(CFG_SERVICE_PORT, 16'hFFFF);
        write_reg(CFG_MIN_COUNT, 16'hFFFF);
        random_phase(300);
        send_gap_pct = 83;
        write_reg(CFG_SERVICE_PORT, 16'h0000);
        write_reg(CFG_MIN_COUNT, 16'd1);
        random_phase(300);
        send_gap_pct = 0;
        write_reg(CFG_SERVICE_PORT, SVC_PORT_DEFAULT);
        write_reg(CFG_MIN_COUNT, 16'd2);
        random_phase(550);

        drain();
        if (sb.errors == 0 && sb.owed_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
